@@ design/timer_table_with_allocation_defines.svh @@
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Clocked, reset-qualified property wrappers shared by the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef TIMER_TABLE_WITH_ALLOCATION_DEFINES_SVH
`define TIMER_TABLE_WITH_ALLOCATION_DEFINES_SVH

// check a condition at every clock edge outside reset
`define TTAB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("timer table assertion failed");

// check a consequence in the cycle after its trigger
`define TTAB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

@@ design/ttab_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, operation and status codes, sequencer states and the control
// bundles passed between the sequencer and the result stage.
// ----------------------------------------------------------------------------
package ttab_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int OP_W       = 3;
  localparam int ID_W       = 8;
  localparam int COUNT_W    = 14;
  localparam int STATUS_W   = 2;
  localparam int WHICH_W    = 6;

  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
  localparam logic [OP_W-1:0] OP_START   = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_CREATED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXPIRED = 2'd2;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_REPLY,
    S_READ,
    S_EVAL,
    S_FLUSH
  } ctrl_state_e;

  typedef struct packed {
    logic                create_res;
    logic                expire;
    logic                flush;
    logic [STATUS_W-1:0] status;
    slot_t               slot;
  } res_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pend_valid;
  } res_sts_t;

endpackage

@@ design/ttab_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ttab_result.sv @@
// ----------------------------------------------------------------------------
// Timer table result stage
// Output register plus one held expiry, so the final expiry of a tick can
// be marked last once the sweep is over.
// ----------------------------------------------------------------------------
module ttab_result import ttab_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  res_cmd_t            cmd_i,
  output res_sts_t            sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [WHICH_W-1:0]  which_timer_o,
  output logic                last_o
);

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [WHICH_W-1:0]  which_q, which_d;
  logic                last_q, last_d;
  logic                pend_valid_q, pend_valid_d;
  slot_t               pend_slot_q, pend_slot_d;
  logic                out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    which_d      = which_q;
    last_d       = last_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    if (cmd_i.create_res) begin
      out_valid_d = 1'b1;
      status_d    = cmd_i.status;
      which_d     = WHICH_W'(cmd_i.slot);
      last_d      = 1'b1;
    end
    if (cmd_i.expire) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        status_d    = STATUS_EXPIRED;
        which_d     = WHICH_W'(pend_slot_q);
        last_d      = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_slot_d  = cmd_i.slot;
    end
    if (cmd_i.flush && pend_valid_q) begin
      out_valid_d  = 1'b1;
      status_d     = STATUS_EXPIRED;
      which_d      = WHICH_W'(pend_slot_q);
      last_d       = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    which_q     <= which_d;
    last_q      <= last_d;
    pend_slot_q <= pend_slot_d;
  end

  assign sts_o.out_free   = out_free;
  assign sts_o.pend_valid = pend_valid_q;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign which_timer_o    = which_q;
  assign last_o           = last_q;

endmodule

@@ design/ttab_ctrl.sv @@
// ----------------------------------------------------------------------------
// Timer table sequencer
// Holds the created and armed flags, steps one slot index through the
// free-slot search and the tick sweep, and drives the count memory and
// the shared decrement-and-compare unit.
// ----------------------------------------------------------------------------
`include "timer_table_with_allocation_defines.svh"

module ttab_ctrl import ttab_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [OP_W-1:0] operation_i,
  input  logic [ID_W-1:0] timer_id_i,
  input  count_t          timeout_i,
  input  res_sts_t        sts_i,
  output res_cmd_t        cmd_o,
  output logic            ram_we_o,
  output slot_t           ram_waddr_o,
  output count_t          ram_wdata_o,
  output logic            ram_re_o,
  output slot_t           ram_raddr_o,
  input  count_t          ram_rdata_i
);

  ctrl_state_e           state_q, state_d;
  slot_t                 idx_q, idx_d;
  logic [NUM_TIMERS-1:0] created_q, created_d;
  logic [NUM_TIMERS-1:0] armed_q, armed_d;
  logic                  found_q, found_d;

  logic  in_acc;
  logic  id_ok;
  slot_t id_slot;
  logic  idx_last;
  logic  slot_active;
  logic  slot_expire;
  logic  eval_blocked;

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign id_ok        = timer_id_i < ID_W'(NUM_TIMERS);
  assign id_slot      = timer_id_i[SLOT_W-1:0];
  assign idx_last     = (idx_q == SLOT_W'(NUM_TIMERS - 1));
  assign slot_active  = created_q[idx_q] && armed_q[idx_q];
  assign slot_expire  = slot_active && (ram_rdata_i <= COUNT_W'(1));
  assign eval_blocked = slot_expire && sts_i.pend_valid && !sts_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (operation_i)
            OP_CREATE: state_d = S_FIND;
            OP_TICK:   state_d = S_READ;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (!created_q[idx_q] || idx_last) state_d = S_REPLY;
      end
      S_REPLY: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (!eval_blocked) state_d = idx_last ? S_FLUSH : S_READ;
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid || sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    created_d   = created_q;
    armed_d     = armed_q;
    idx_d       = idx_q;
    found_d     = found_q;
    cmd_o       = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = ram_rdata_i - COUNT_W'(1);
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (operation_i)
            OP_CREATE: idx_d = '0;
            OP_DESTROY: begin
              if (id_ok) begin
                created_d[id_slot] = 1'b0;
                armed_d[id_slot]   = 1'b0;
              end
            end
            OP_START: begin
              if (id_ok) begin
                armed_d[id_slot] = 1'b1;
                ram_we_o         = 1'b1;
                ram_waddr_o      = id_slot;
                ram_wdata_o      = timeout_i;
              end
            end
            OP_STOP: begin
              if (id_ok) armed_d[id_slot] = 1'b0;
            end
            OP_TICK: idx_d = '0;
            default: ;
          endcase
        end
      end
      S_FIND: begin
        if (!created_q[idx_q]) begin
          created_d[idx_q] = 1'b1;
          armed_d[idx_q]   = 1'b0;
          found_d          = 1'b1;
        end else if (idx_last) begin
          found_d = 1'b0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.create_res = 1'b1;
          cmd_o.status     = found_q ? STATUS_CREATED : STATUS_NO_FREE;
          cmd_o.slot       = found_q ? idx_q : '0;
        end
      end
      S_READ: ram_re_o = 1'b1;
      S_EVAL: begin
        if (!eval_blocked) begin
          if (slot_expire) begin
            armed_d[idx_q] = 1'b0;
            cmd_o.expire   = 1'b1;
            cmd_o.slot     = idx_q;
          end else if (slot_active) begin
            ram_we_o = 1'b1;
          end
          if (!idx_last) idx_d = idx_q + 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts_i.pend_valid && sts_i.out_free) cmd_o.flush = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      created_q <= '0;
      armed_q   <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      created_q <= created_d;
      armed_q   <= armed_d;
      found_q   <= found_d;
    end
  end

  `TTAB_ASSERT_NEXT(a_claim_disarms, state_q == S_FIND && !created_q[idx_q],
                    created_q[$past(idx_q)] && !armed_q[$past(idx_q)] && state_q == S_REPLY)
  `TTAB_ASSERT(a_expire_active, !cmd_o.expire || (created_q[idx_q] && armed_q[idx_q]))
  `TTAB_ASSERT_NEXT(a_sweep_steps, state_q == S_EVAL && !eval_blocked && !idx_last,
                    state_q == S_READ && idx_q == $past(idx_q) + 1'b1)
  `TTAB_ASSERT(a_res_in_busy, !(cmd_o.create_res || cmd_o.expire || cmd_o.flush) || in_stall_o)

endmodule

@@ design/timer_table_with_allocation.sv @@
// ----------------------------------------------------------------------------
// Timer table with allocation
// A bank of NUM_TIMERS one-shot countdown timers. Requests enter on the
// in_valid_i / in_stall_o channel: create, destroy, start, stop or tick.
// Destroy, start and stop give no result. Create scans for the lowest
// free slot one slot a cycle and returns one result. A tick sweeps
// every slot through the count RAM and the shared decrement unit; each
// expiry gives a result in slot order, the final one marked by last_o,
// so it trails by one expiry. in_stall_o is high while a create or
// tick is in progress. Results leave through an output register on
// out_valid_o / out_stall_i; a stalled result holds, and the sweep
// waits only when a second expiry finds the register still full. Reset
// clears all flags and returns the block to idle at once; the count
// RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module timer_table_with_allocation import ttab_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [ID_W-1:0]     timer_id_i,
  input  logic [COUNT_W-1:0]  timeout_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [WHICH_W-1:0]  which_timer_o,
  output logic                last_o
);

  res_cmd_t res_cmd;
  res_sts_t res_sts;
  logic     ram_we;
  slot_t    ram_waddr;
  count_t   ram_wdata;
  logic     ram_re;
  slot_t    ram_raddr;
  count_t   ram_rdata;

  ttab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .timer_id_i  (timer_id_i),
    .timeout_i   (timeout_i),
    .sts_i       (res_sts),
    .cmd_o       (res_cmd),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ttab_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_TIMERS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ttab_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (res_cmd),
    .sts_o         (res_sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .which_timer_o (which_timer_o),
    .last_o        (last_o)
  );

endmodule
